// ===== hw/rtl/esmd_pkg.sv =====
// Shared types, codes and helpers for the elementwise scaled multiply/divide block.
// Used by every module under hw/rtl; depends on nothing.
package esmd_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        MODE_MUL_PUT = 2'd0,
        MODE_MUL_ADD = 2'd1,
        MODE_DIV_PUT = 2'd2,
        MODE_DIV_ADD = 2'd3
    } op_mode_t;

    typedef enum logic [0:0] {
        REG_OP_MODE = 1'b0,
        REG_SCALE   = 1'b1
    } reg_index_t;

    // Control word that travels with every item down the pipeline.
    typedef struct packed {
        logic     valid;
        op_mode_t mode;
        logic     neg;   // sign of the term, or of the saturated value on divide by zero
        logic     div0;
    } ctl_t;

    function automatic logic mode_is_div(input op_mode_t m);
        return (m == MODE_DIV_PUT) || (m == MODE_DIV_ADD);
    endfunction

    function automatic logic mode_is_add(input op_mode_t m);
        return (m == MODE_MUL_ADD) || (m == MODE_DIV_ADD);
    endfunction

endpackage

// ===== hw/rtl/esmd_front.sv =====
// Front end: sign split, a*k product and the (a*k)*b product in partial products.
// Depends on esmd_pkg.
module esmd_front #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  esmd_pkg::op_mode_t      mode,
    input  logic [DATA_WIDTH-1:0]   scale,
    input  logic [DATA_WIDTH-1:0]   dest_value,
    input  logic [DATA_WIDTH-1:0]   source_value,
    output esmd_pkg::ctl_t          ctl_out,
    output logic [2*DATA_WIDTH-1:0] num_out,
    output logic [DATA_WIDTH-1:0]   div_out,
    output logic [DATA_WIDTH-1:0]   a_out,
    output logic [3*DATA_WIDTH-1:0] prod_out
);
    import esmd_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam logic [3*W-1:0] RND = (3*W)'(1) << (2*FRAC_BITS - 1);

    logic         sa, sb, sk;
    logic [W-1:0] ma, mb, mk;
    ctl_t         ctl_in;

    ctl_t           ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic [2*W-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic [W-1:0]   b1_reg, b2_reg, b3_reg, b4_reg;
    logic [W-1:0]   a1_reg, a2_reg, a3_reg, a4_reg;
    logic [2*W-1:0] lo2_reg, lo3_reg, hi3_reg;
    logic [3*W-1:0] prod4_reg, prod4_next;

    always_comb
    begin
        sa = dest_value[W-1];
        sb = source_value[W-1];
        sk = scale[W-1];
        ma = sa ? (~dest_value + W'(1)) : dest_value;
        mb = sb ? (~source_value + W'(1)) : source_value;
        mk = sk ? (~scale + W'(1)) : scale;
        ctl_in.valid = accept;
        ctl_in.mode  = mode;
        ctl_in.div0  = mode_is_div(mode) && (mb == '0);
        // on divide by zero the sign is that of a*k, zero counts as positive
        ctl_in.neg   = ctl_in.div0 ? ((ma != '0) && (mk != '0) && (sa ^ sk))
                                   : (sa ^ sb ^ sk);
    end

    always_comb
    begin
        prod4_next = {hi3_reg, {W{1'b0}}} + {{W{1'b0}}, lo3_reg} + RND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg    <= ma * mk;
        b1_reg    <= mb;
        a1_reg    <= dest_value;
        lo2_reg   <= p1_reg[W-1:0] * b1_reg;
        p2_reg    <= p1_reg;
        b2_reg    <= b1_reg;
        a2_reg    <= a1_reg;
        hi3_reg   <= p2_reg[2*W-1:W] * b2_reg;
        lo3_reg   <= lo2_reg;
        p3_reg    <= p2_reg;
        b3_reg    <= b2_reg;
        a3_reg    <= a2_reg;
        prod4_reg <= prod4_next;
        p4_reg    <= p3_reg;
        b4_reg    <= b3_reg;
        a4_reg    <= a3_reg;
    end

    assign ctl_out  = ctl4_reg;
    assign num_out  = p4_reg;
    assign div_out  = b4_reg;
    assign a_out    = a4_reg;
    assign prod_out = prod4_reg;

endmodule

// ===== hw/rtl/esmd_div_cell.sv =====
// One cell of the divider chain: one restoring quotient bit per cell.
// Depends on esmd_pkg.
module esmd_div_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  esmd_pkg::ctl_t          ctl_in,
    input  logic [2*DATA_WIDTH-1:0] num_in,
    input  logic [DATA_WIDTH-1:0]   rem_in,
    input  logic [DATA_WIDTH-1:0]   div_in,
    input  logic [DATA_WIDTH-1:0]   a_in,
    input  logic [3*DATA_WIDTH-1:0] prod_in,
    output esmd_pkg::ctl_t          ctl_out,
    output logic [2*DATA_WIDTH-1:0] num_out,
    output logic [DATA_WIDTH-1:0]   rem_out,
    output logic [DATA_WIDTH-1:0]   div_out,
    output logic [DATA_WIDTH-1:0]   a_out,
    output logic [3*DATA_WIDTH-1:0] prod_out
);
    import esmd_pkg::*;

    localparam int W = DATA_WIDTH;

    ctl_t           ctl_reg;
    logic [2*W-1:0] num_reg, num_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [W-1:0]   div_reg, a_reg;
    logic [3*W-1:0] prod_reg;
    logic [W:0]     trial, diff;
    logic           qbit;

    // shift the next numerator bit into the remainder, subtract if it fits
    always_comb
    begin
        trial    = {rem_in, num_in[2*W-1]};
        diff     = trial - {1'b0, div_in};
        qbit     = (trial >= {1'b0, div_in});
        rem_next = qbit ? diff[W-1:0] : trial[W-1:0];
        num_next = {num_in[2*W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        div_reg  <= div_in;
        a_reg    <= a_in;
        prod_reg <= prod_in;
    end

    assign ctl_out  = ctl_reg;
    assign num_out  = num_reg;
    assign rem_out  = rem_reg;
    assign div_out  = div_reg;
    assign a_out    = a_reg;
    assign prod_out = prod_reg;

endmodule

// ===== hw/rtl/esmd_back.sv =====
// Back end: rounding, sign, optional accumulate into a, saturation, result register.
// Depends on esmd_pkg.
module esmd_back #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  esmd_pkg::ctl_t          ctl_in,
    input  logic [2*DATA_WIDTH-1:0] quot_in,
    input  logic [DATA_WIDTH-1:0]   rem_in,
    input  logic [DATA_WIDTH-1:0]   div_in,
    input  logic [DATA_WIDTH-1:0]   a_in,
    input  logic [3*DATA_WIDTH-1:0] prod_in,
    output logic                    done,
    output logic [DATA_WIDTH-1:0]   new_value,
    output logic                    overflowed,
    output logic                    divided_by_zero
);
    import esmd_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int E = 3*W + 1;
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    ctl_t         ctl_reg;
    logic [E-1:0] term_reg, term_next;
    logic [W-1:0] a_reg;
    logic [3*W-1:0] mag;
    logic           rnd_up;

    logic [E-1:0] sum;
    logic         sat;
    logic [W-1:0] val_next;
    logic         ovf_next;

    logic         done_reg;
    logic [W-1:0] val_reg;
    logic         ovf_reg, d0_reg;

    always_comb
    begin
        rnd_up = ({rem_in, 1'b0} >= {1'b0, div_in});
        if (mode_is_div(ctl_in.mode))
            mag = {{W{1'b0}}, quot_in} + (3*W)'(rnd_up);
        else
            mag = prod_in >> (2*FRAC_BITS);
        term_next = ctl_in.neg ? (~{1'b0, mag} + E'(1)) : {1'b0, mag};
    end

    always_comb
    begin
        sum = term_reg;
        if (mode_is_add(ctl_reg.mode))
            sum = term_reg + {{(E-W){a_reg[W-1]}}, a_reg};
        sat      = (sum[E-1:W-1] != '0) && (sum[E-1:W-1] != '1);
        ovf_next = 1'b0;
        if (ctl_reg.div0)
            val_next = ctl_reg.neg ? VMIN : VMAX;
        else if (sat)
        begin
            val_next = sum[E-1] ? VMIN : VMAX;
            ovf_next = 1'b1;
        end
        else
            val_next = sum[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl_in;
            done_reg <= ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
        a_reg    <= a_in;
        val_reg  <= val_next;
        ovf_reg  <= ovf_next;
        d0_reg   <= ctl_reg.div0;
    end

    assign done            = done_reg;
    assign new_value       = val_reg;
    assign overflowed      = ovf_reg;
    assign divided_by_zero = d0_reg;

endmodule

// ===== hw/rtl/elementwise_scaled_mul_div.sv =====
// Top level of the elementwise scaled multiply/divide block.
// Depends on esmd_pkg, esmd_front, esmd_div_cell and esmd_back.
//
// Usage:
//   Drive dest_value (a) and source_value (b), signed fixed point, with start
//   high; the pair transfers at that clock edge when busy is low. busy stays
//   low, so one pair can transfer on every cycle.
//   op_mode and scale_factor are written through wr_en / wr_index / wr_data;
//   write them only while no pair is in flight.
//   Each pair yields one result: new_value, overflowed and divided_by_zero
//   are valid in the single cycle in which done is high. The receiver cannot
//   stall; results are not held.
// Throughput and structure:
//   One pair per cycle, through one divider cell per quotient bit of the
//   2*DATA_WIDTH-bit product a*k, plus four front stages (sign split and
//   a*k, then two partial products of (a*k)*b and their sum) and two back
//   stages (round and sign, then add and saturate). Multiply modes travel
//   the same chain so results leave in order.
// Reset:
//   Clear every valid bit in the pipeline; op_mode returns to multiply-put
//   and scale_factor to 1.0.
module elementwise_scaled_mul_div #(
    parameter int DATA_WIDTH = esmd_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = esmd_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  wr_en,
    input  esmd_pkg::reg_index_t  wr_index,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [DATA_WIDTH-1:0] dest_value,
    input  logic [DATA_WIDTH-1:0] source_value,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] new_value,
    output logic                  overflowed,
    output logic                  divided_by_zero
);
    import esmd_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int N = 2*W;   // divider cells, one per quotient bit
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

    op_mode_t     mode_reg;
    logic [W-1:0] scale_reg;
    logic         accept;

    // chain taps: index 0 is the front end output, index N the last cell
    ctl_t           ctl_c  [N+1];
    logic [2*W-1:0] num_c  [N+1];
    logic [W-1:0]   rem_c  [N+1];
    logic [W-1:0]   div_c  [N+1];
    logic [W-1:0]   a_c    [N+1];
    logic [3*W-1:0] prod_c [N+1];

    // the pipeline never refuses a pair
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_MUL_PUT;
            scale_reg <= ONE;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_OP_MODE: mode_reg  <= op_mode_t'(wr_data[1:0]);
                REG_SCALE:   scale_reg <= wr_data;
                default:     mode_reg  <= mode_reg;
            endcase
        end
    end

    esmd_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .mode         (mode_reg),
        .scale        (scale_reg),
        .dest_value   (dest_value),
        .source_value (source_value),
        .ctl_out      (ctl_c[0]),
        .num_out      (num_c[0]),
        .div_out      (div_c[0]),
        .a_out        (a_c[0]),
        .prod_out     (prod_c[0])
    );

    // partial remainder starts at zero
    assign rem_c[0] = '0;

    // one quotient bit per cell, most significant first
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        esmd_div_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (ctl_c[i]),
            .num_in   (num_c[i]),
            .rem_in   (rem_c[i]),
            .div_in   (div_c[i]),
            .a_in     (a_c[i]),
            .prod_in  (prod_c[i]),
            .ctl_out  (ctl_c[i+1]),
            .num_out  (num_c[i+1]),
            .rem_out  (rem_c[i+1]),
            .div_out  (div_c[i+1]),
            .a_out    (a_c[i+1]),
            .prod_out (prod_c[i+1])
        );
    end

    // round, sign, accumulate, saturate, then drive the result for one cycle
    esmd_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl_in          (ctl_c[N]),
        .quot_in         (num_c[N]),
        .rem_in          (rem_c[N]),
        .div_in          (div_c[N]),
        .a_in            (a_c[N]),
        .prod_in         (prod_c[N]),
        .done            (done),
        .new_value       (new_value),
        .overflowed      (overflowed),
        .divided_by_zero (divided_by_zero)
    );

endmodule

// ===== hw/rtl/esmd_checker.sv =====
// Port-level checks for the elementwise scaled multiply/divide block, and its bind.
// Depends on esmd_pkg and elementwise_scaled_mul_div.
module esmd_checker #(
    parameter int DATA_WIDTH = esmd_pkg::DATA_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [DATA_WIDTH-1:0] new_value,
    input logic                  overflowed,
    input logic                  divided_by_zero
);
    import esmd_pkg::*;

    localparam int LAT = 2*DATA_WIDTH + 6;
    localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // every transfer yields exactly one result after the fixed latency
    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after transfer");

    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching transfer");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divided_by_zero) |-> !overflowed)
        else $error("divide by zero flagged as overflow");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (overflowed || divided_by_zero)) |->
            (new_value == VMAX || new_value == VMIN))
        else $error("saturated result not at full scale");

endmodule

bind elementwise_scaled_mul_div esmd_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_esmd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .new_value       (new_value),
    .overflowed      (overflowed),
    .divided_by_zero (divided_by_zero)
);
